/* src/bdpc_pkg.sv */
// Package for the button debounce and press classifier.
// Holds the register index codes, the configuration struct and the result struct.
// No dependencies.
package bdpc_pkg;

    // Field widths fixed by the interface
    localparam int unsigned TickInBits = 32;
    localparam int unsigned TotalBits  = 8;
    localparam int unsigned TimeBits   = 16;
    localparam int unsigned EnBits     = 4;
    localparam int unsigned CfgIdxBits = 3;

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxBits-1:0] {
        REG_ACTIVE_LOW     = 3'd0,
        REG_DEBOUNCE_MS    = 3'd1,
        REG_LONG_PRESS_MS  = 3'd2,
        REG_MULTI_RESET_MS = 3'd3,
        REG_EVENT_ENABLE   = 3'd4
    } t_reg_idx;

    // Bit positions in event_enable
    localparam int unsigned EnPress = 0;
    localparam int unsigned EnLong  = 1;
    localparam int unsigned EnDown  = 2;
    localparam int unsigned EnUp    = 3;

    // Reset values of the registers
    localparam logic                DefActiveLow   = 1'b0;
    localparam logic [TimeBits-1:0] DefDebounce    = 16'd50;
    localparam logic [TimeBits-1:0] DefLongPress   = 16'd1000;
    localparam logic [TimeBits-1:0] DefMultiReset  = 16'd500;
    localparam logic [EnBits-1:0]   DefEventEnable = 4'd0;

    typedef struct packed {
        logic                active_low;
        logic [TimeBits-1:0] debounce_ms;
        logic [TimeBits-1:0] long_press_ms;
        logic [TimeBits-1:0] multi_reset_ms;
        logic [EnBits-1:0]   event_enable;
    } t_cfg;

    typedef struct packed {
        logic                 down_event;
        logic                 press_event;
        logic                 long_event;
        logic                 up_event;
        logic [TotalBits-1:0] press_total;
        logic                 held_now;
    } t_result;

endpackage

/* src/button_debounce_press_classifier.sv */
// Button debounce and press classifier, top level.
// A poll passes the input register, then the result register. The state update is
// one pass of compare logic. Throughput: one poll per cycle unless the sink stalls.
// Reset: synchronous active low; clears both pipeline valids and the press state,
// and loads the register defaults. Depends on bdpc_pkg, bdpc_cfg and bdpc_core.
module button_debounce_press_classifier #(
    parameter int unsigned TICK_BITS  = 32,
    parameter int unsigned COUNT_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Poll channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_pin_level,
    input  logic [bdpc_pkg::TickInBits-1:0] i_now_ticks,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_down_event,
    output logic                            o_press_event,
    output logic                            o_long_event,
    output logic                            o_up_event,
    output logic [bdpc_pkg::TotalBits-1:0]  o_press_total,
    output logic                            o_held_now,
    // Configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bdpc_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [bdpc_pkg::TimeBits-1:0]   i_cfg_data
);

    bdpc_pkg::t_cfg                  cfg;
    bdpc_pkg::t_result               result;
    bdpc_pkg::t_result               r_out;
    logic                            r_out_valid;
    logic                            r_s1_valid;
    logic                            r_s1_level;
    logic [bdpc_pkg::TickInBits-1:0] r_s1_now;
    logic                            advance;

    assign o_cfg_ready = 1'b1;

    bdpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Move the held poll into the result register when that slot frees up
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    bdpc_core #(
        .TICK_BITS  (TICK_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_level  (r_s1_level),
        .i_now    (r_s1_now),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register: hold a poll until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_level <= i_pin_level;
            r_s1_now   <= i_now_ticks;
        end
    end

    // Result register: hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_down_event  = r_out.down_event;
    assign o_press_event = r_out.press_event;
    assign o_long_event  = r_out.long_event;
    assign o_up_event    = r_out.up_event;
    assign o_press_total = r_out.press_total;
    assign o_held_now    = r_out.held_now;

endmodule

/* src/bdpc_cfg.sv */
// Configuration register bank for the button debounce and press classifier.
// Depends on bdpc_pkg for register indexes, reset values and the t_cfg struct.
module bdpc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [bdpc_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [bdpc_pkg::TimeBits-1:0]   i_cfg_data,
    output bdpc_pkg::t_cfg                  o_cfg
);

    bdpc_pkg::t_cfg r_cfg;

    // Take one register write per transaction; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low     <= bdpc_pkg::DefActiveLow;
            r_cfg.debounce_ms    <= bdpc_pkg::DefDebounce;
            r_cfg.long_press_ms  <= bdpc_pkg::DefLongPress;
            r_cfg.multi_reset_ms <= bdpc_pkg::DefMultiReset;
            r_cfg.event_enable   <= bdpc_pkg::DefEventEnable;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bdpc_pkg::REG_ACTIVE_LOW:     r_cfg.active_low     <= i_cfg_data[0];
                bdpc_pkg::REG_DEBOUNCE_MS:    r_cfg.debounce_ms    <= i_cfg_data;
                bdpc_pkg::REG_LONG_PRESS_MS:  r_cfg.long_press_ms  <= i_cfg_data;
                bdpc_pkg::REG_MULTI_RESET_MS: r_cfg.multi_reset_ms <= i_cfg_data;
                bdpc_pkg::REG_EVENT_ENABLE:
                    r_cfg.event_enable <= i_cfg_data[bdpc_pkg::EnBits-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/bdpc_core.sv */
// Press classifier state and the per-poll update logic.
// Depends on bdpc_pkg for t_cfg, t_result and the event_enable bit positions.
module bdpc_core #(
    parameter int unsigned TICK_BITS  = 32,
    parameter int unsigned COUNT_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_level,
    input  logic [bdpc_pkg::TickInBits-1:0]   i_now,
    input  bdpc_pkg::t_cfg                    i_cfg,
    output bdpc_pkg::t_result                 o_result
);

    typedef struct packed {
        logic pending;
        logic down;
        logic press;
    } t_notify;

    logic [TICK_BITS-1:0]  r_last_rel, n_last_rel;
    logic [TICK_BITS-1:0]  r_start,    n_start;
    logic [COUNT_BITS-1:0] r_count,    n_count;
    logic                  r_pressed,  n_pressed;
    logic                  r_long_done, n_long_done;
    logic                  r_pending,  n_pending;

    logic [TICK_BITS-1:0]  now;
    logic [TICK_BITS-1:0]  since_rel;
    logic [TICK_BITS-1:0]  held;
    logic                  active;
    logic                  ev_down, ev_press, ev_long, ev_up;
    t_notify               note;

    // Press notification: gated by the press enable, deferred in long-press mode
    function automatic t_notify notify(input logic [bdpc_pkg::EnBits-1:0] en,
                                       input logic pending);
        t_notify r;
        r.pending = pending;
        r.down    = 1'b0;
        r.press   = 1'b0;
        if (en[bdpc_pkg::EnPress]) begin
            r.down = en[bdpc_pkg::EnDown];
            if (en[bdpc_pkg::EnLong]) begin
                r.pending = !pending;
                r.press   = pending;
            end else begin
                r.press = 1'b1;
            end
        end
        return r;
    endfunction

    assign now       = TICK_BITS'(i_now);
    assign active    = i_cfg.active_low ? !i_level : i_level;
    assign since_rel = now - r_last_rel;
    assign held      = now - r_start;
    assign note      = notify(i_cfg.event_enable, r_pending);

    // Classify one poll against the held state
    always_comb begin
        n_last_rel  = r_last_rel;
        n_start     = r_start;
        n_count     = r_count;
        n_pressed   = r_pressed;
        n_long_done = r_long_done;
        n_pending   = r_pending;
        ev_down     = 1'b0;
        ev_press    = 1'b0;
        ev_long     = 1'b0;
        ev_up       = 1'b0;
        if (active) begin
            if (since_rel > TICK_BITS'(i_cfg.debounce_ms)) begin
                if (!r_pressed) begin
                    n_count   = r_count + 1'b1;
                    n_start   = now;
                    n_pressed = 1'b1;
                    n_pending = note.pending;
                    ev_down   = note.down;
                    ev_press  = note.press;
                end else if (!r_long_done) begin
                    if (held >= TICK_BITS'(i_cfg.long_press_ms)) begin
                        n_pending   = 1'b0;
                        n_long_done = 1'b1;
                        ev_long     = i_cfg.event_enable[bdpc_pkg::EnLong];
                    end
                end
            end
        end else begin
            n_last_rel  = now;
            n_pressed   = 1'b0;
            n_long_done = 1'b0;
            if (r_pending) begin
                n_pending = note.pending;
                ev_down   = note.down;
                ev_press  = note.press;
            end
            // Idle window since the last press start clears the count
            if (held >= TICK_BITS'(i_cfg.multi_reset_ms)) begin
                n_count = '0;
                ev_up   = i_cfg.event_enable[bdpc_pkg::EnUp];
            end
        end
    end

    // Advance the state once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rel  <= '0;
            r_start     <= '0;
            r_count     <= '0;
            r_pressed   <= 1'b0;
            r_long_done <= 1'b0;
            r_pending   <= 1'b0;
        end else if (i_step) begin
            r_last_rel  <= n_last_rel;
            r_start     <= n_start;
            r_count     <= n_count;
            r_pressed   <= n_pressed;
            r_long_done <= n_long_done;
            r_pending   <= n_pending;
        end
    end

    assign o_result.down_event  = ev_down;
    assign o_result.press_event = ev_press;
    assign o_result.long_event  = ev_long;
    assign o_result.up_event    = ev_up;
    assign o_result.press_total = bdpc_pkg::TotalBits'(n_count);
    assign o_result.held_now    = n_pressed;

endmodule

/* tb/testbench.sv */
// Testbench for button_debounce_press_classifier: poll, result and register channels.
// Holds a scoreboard class that predicts each result and plain tasks that drive the block.
// Depends on bdpc_pkg and the block's RTL.
module testbench;

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned RxHoldCycles  = 300;
    localparam int unsigned ReportLimit   = 10;

    // Predicts the result of every poll and checks the results the block returns
    class press_scoreboard;
        bdpc_pkg::t_cfg    cfg;
        logic [31:0]       release_tick;
        logic [31:0]       start_tick;
        logic [7:0]        presses;
        logic              held;
        logic              long_seen;
        logic              short_pending;
        bdpc_pkg::t_result res;
        bdpc_pkg::t_result awaited_results[$];
        int unsigned       n_checked;
        int unsigned       n_errors;
        int unsigned       n_down;
        int unsigned       n_press;
        int unsigned       n_long;
        int unsigned       n_up;

        function new();
            cfg.active_low     = bdpc_pkg::DefActiveLow;
            cfg.debounce_ms    = bdpc_pkg::DefDebounce;
            cfg.long_press_ms  = bdpc_pkg::DefLongPress;
            cfg.multi_reset_ms = bdpc_pkg::DefMultiReset;
            cfg.event_enable   = bdpc_pkg::DefEventEnable;
            release_tick  = '0;
            start_tick    = '0;
            presses       = '0;
            held          = 1'b0;
            long_seen     = 1'b0;
            short_pending = 1'b0;
            n_checked = 0;
            n_errors  = 0;
            n_down    = 0;
            n_press   = 0;
            n_long    = 0;
            n_up      = 0;
        endfunction

        function void write_reg(bdpc_pkg::t_reg_idx idx, logic [bdpc_pkg::TimeBits-1:0] data);
            case (idx)
                bdpc_pkg::REG_ACTIVE_LOW:     cfg.active_low     = data[0];
                bdpc_pkg::REG_DEBOUNCE_MS:    cfg.debounce_ms    = data;
                bdpc_pkg::REG_LONG_PRESS_MS:  cfg.long_press_ms  = data;
                bdpc_pkg::REG_MULTI_RESET_MS: cfg.multi_reset_ms = data;
                bdpc_pkg::REG_EVENT_ENABLE:
                    cfg.event_enable = data[bdpc_pkg::EnBits-1:0];
                default: ;
            endcase
        endfunction

        // Raise down/press strobes; in long-press mode the first call defers the press strobe
        function void announce_press();
            if (!cfg.event_enable[bdpc_pkg::EnPress])
                return;
            if (cfg.event_enable[bdpc_pkg::EnDown])
                res.down_event = 1'b1;
            if (cfg.event_enable[bdpc_pkg::EnLong]) begin
                if (!short_pending) begin
                    short_pending = 1'b1;
                    return;
                end
                short_pending = 1'b0;
            end
            res.press_event = 1'b1;
        endfunction

        // Advance the press state by one accepted poll and queue its result
        function void note_poll(logic level, logic [31:0] now);
            logic        active;
            logic [31:0] span;
            active = cfg.active_low ? !level : level;
            res = '0;
            if (active) begin
                span = now - release_tick;
                if (span > {16'd0, cfg.debounce_ms}) begin
                    if (!held) begin
                        presses    = presses + 8'd1;
                        start_tick = now;
                        held       = 1'b1;
                        announce_press();
                    end else if (!long_seen) begin
                        span = now - start_tick;
                        if (span >= {16'd0, cfg.long_press_ms}) begin
                            short_pending = 1'b0;
                            long_seen     = 1'b1;
                            if (cfg.event_enable[bdpc_pkg::EnLong])
                                res.long_event = 1'b1;
                        end
                    end
                end
            end else begin
                release_tick = now;
                held         = 1'b0;
                long_seen    = 1'b0;
                if (short_pending)
                    announce_press();
                span = now - start_tick;
                if (span >= {16'd0, cfg.multi_reset_ms}) begin
                    presses = '0;
                    if (cfg.event_enable[bdpc_pkg::EnUp])
                        res.up_event = 1'b1;
                end
            end
            res.press_total = presses;
            res.held_now    = held;
            awaited_results.push_back(res);
        endfunction

        // Compare one returned result with the oldest prediction
        function void check_result(bdpc_pkg::t_result got);
            bdpc_pkg::t_result want;
            n_checked++;
            if (awaited_results.size() == 0) begin
                n_errors++;
                if (n_errors <= ReportLimit)
                    $display("result %0d arrived with no poll waiting for it", n_checked);
                return;
            end
            want = awaited_results.pop_front();
            n_down  += {31'd0, want.down_event};
            n_press += {31'd0, want.press_event};
            n_long  += {31'd0, want.long_event};
            n_up    += {31'd0, want.up_event};
            if (got.down_event !== want.down_event || got.press_event !== want.press_event ||
                got.long_event !== want.long_event || got.up_event !== want.up_event ||
                got.press_total !== want.press_total || got.held_now !== want.held_now) begin
                n_errors++;
                if (n_errors <= ReportLimit) begin
                    $display("mismatch at result %0d, expected: down %b press %b long %b up %b",
                             n_checked, want.down_event, want.press_event,
                             want.long_event, want.up_event);
                    $display("    expected total %0d held %b", want.press_total, want.held_now);
                    $display("    actual: down %b press %b long %b up %b total %0d held %b",
                             got.down_event, got.press_event, got.long_event,
                             got.up_event, got.press_total, got.held_now);
                end
            end
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_pin_level;
    logic [bdpc_pkg::TickInBits-1:0] i_now_ticks;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic                            o_down_event;
    logic                            o_press_event;
    logic                            o_long_event;
    logic                            o_up_event;
    logic [bdpc_pkg::TotalBits-1:0]  o_press_total;
    logic                            o_held_now;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [bdpc_pkg::CfgIdxBits-1:0] i_cfg_index;
    logic [bdpc_pkg::TimeBits-1:0]   i_cfg_data;

    press_scoreboard   sb;
    bdpc_pkg::t_result seen_result;
    logic [31:0]       tick_now;
    int unsigned       polls_sent;
    int unsigned       reg_writes;
    int unsigned       tx_idle_pct;
    int unsigned       rx_stall_pct;
    int unsigned       rx_hold_requests;
    int unsigned       quiet_cycles;

    button_debounce_press_classifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pin_level   (i_pin_level),
        .i_now_ticks   (i_now_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_down_event  (o_down_event),
        .o_press_event (o_press_event),
        .o_long_event  (o_long_event),
        .o_up_event    (o_up_event),
        .o_press_total (o_press_total),
        .o_held_now    (o_held_now),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result sink: stall at random, or hold off for a long stretch on request
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left    = 0;
        holds_served = 0;
        i_out_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != rx_hold_requests) begin
                holds_served = rx_hold_requests;
                hold_left    = RxHoldCycles;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Monitor: predict on each poll transaction, check each result transaction, watch for hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_poll(i_pin_level, i_now_ticks);
            if (o_out_valid && i_out_ready) begin
                seen_result.down_event  = o_down_event;
                seen_result.press_event = o_press_event;
                seen_result.long_event  = o_long_event;
                seen_result.up_event    = o_up_event;
                seen_result.press_total = o_press_total;
                seen_result.held_now    = o_held_now;
                sb.check_result(seen_result);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.pending());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Offer one poll, idling first at random, and hold it until accepted
    task automatic send_poll(logic level, logic [31:0] now);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_pin_level <= level;
        i_now_ticks <= now;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        polls_sent++;
    endtask

    // Drop the poll valid and wait until every predicted result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(bdpc_pkg::t_reg_idx idx, logic [bdpc_pkg::TimeBits-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Load all five registers; unused upper data bits carry junk that must be masked
    task automatic configure(logic al, logic [15:0] dbn, logic [15:0] lng, logic [15:0] mrs,
                             logic [3:0] en);
        logic [15:0] junk;
        junk      = 16'($urandom);
        junk[0]   = al;
        write_reg(bdpc_pkg::REG_ACTIVE_LOW, junk);
        write_reg(bdpc_pkg::REG_DEBOUNCE_MS, dbn);
        write_reg(bdpc_pkg::REG_LONG_PRESS_MS, lng);
        write_reg(bdpc_pkg::REG_MULTI_RESET_MS, mrs);
        junk      = 16'($urandom);
        junk[3:0] = en;
        write_reg(bdpc_pkg::REG_EVENT_ENABLE, junk);
    endtask

    // One button press: settle released, maybe bounce, hold, release, maybe go idle
    task automatic press_sequence();
        logic        act;
        int unsigned dbn;
        int unsigned lng;
        int unsigned mrs;
        act = !sb.cfg.active_low;
        dbn = {16'd0, sb.cfg.debounce_ms};
        lng = {16'd0, sb.cfg.long_press_ms};
        mrs = {16'd0, sb.cfg.multi_reset_ms};
        repeat ($urandom_range(1, 2)) begin
            tick_now += $urandom_range(0, 40);
            send_poll(!act, tick_now);
        end
        if ($urandom_range(0, 3) == 0) begin
            tick_now += $urandom_range(0, dbn);
            send_poll(act, tick_now);
            tick_now += $urandom_range(0, 5);
            send_poll(!act, tick_now);
        end
        repeat ($urandom_range(1, 5)) begin
            tick_now += $urandom_range(0, (dbn + lng) / 2 + 2);
            send_poll(act, tick_now);
        end
        tick_now += $urandom_range(0, 20);
        send_poll(!act, tick_now);
        if ($urandom_range(0, 1) == 1) begin
            tick_now += $urandom_range(0, mrs + 20);
            send_poll(!act, tick_now);
        end
    endtask

    // Mostly well-formed presses, some single polls with random level and jumping ticks
    task automatic run_random(int unsigned count);
        int unsigned target;
        target = polls_sent + count;
        while (polls_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    tick_now = $urandom;
                else
                    tick_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
                send_poll(1'($urandom_range(0, 1)), tick_now);
            end else begin
                press_sequence();
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_pin_level      = 1'b0;
        i_now_ticks      = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = bdpc_pkg::REG_ACTIVE_LOW;
        i_cfg_data       = '0;
        tick_now         = '0;
        polls_sent       = 0;
        reg_writes       = 0;
        quiet_cycles     = 0;
        rx_hold_requests = 0;
        tx_idle_pct      = 7;
        rx_stall_pct     = 71;
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: debounce edge, short press confirmed on release, long press, idle clear
        write_reg(bdpc_pkg::REG_EVENT_ENABLE, 16'h000F);
        send_poll(1'b0, 32'h0000_0000);
        send_poll(1'b1, 32'd10);
        send_poll(1'b1, 32'd50);
        send_poll(1'b1, 32'd51);
        send_poll(1'b1, 32'd500);
        send_poll(1'b0, 32'd600);
        send_poll(1'b1, 32'd700);
        send_poll(1'b1, 32'd1700);
        send_poll(1'b1, 32'd1800);
        send_poll(1'b0, 32'd1900);
        // Tick wrap across zero
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b0, 32'h0000_0005);
        send_poll(1'b1, 32'h0000_0040);
        send_poll(1'b0, 32'hFFFF_FFFF);
        // Change enables mid-hold with a short press still armed
        send_poll(1'b1, 32'h0000_0100);
        write_reg(bdpc_pkg::REG_EVENT_ENABLE, 16'h0005);
        send_poll(1'b0, 32'h0000_0200);
        write_reg(bdpc_pkg::REG_ACTIVE_LOW, 16'h0001);
        write_reg(bdpc_pkg::REG_EVENT_ENABLE, 16'h000F);
        send_poll(1'b0, 32'h0000_0300);
        send_poll(1'b1, 32'h0000_0310);
        // Zero debounce, zero long press, zero idle window
        write_reg(bdpc_pkg::REG_DEBOUNCE_MS, 16'd0);
        write_reg(bdpc_pkg::REG_LONG_PRESS_MS, 16'd0);
        send_poll(1'b0, 32'h0000_0310);
        send_poll(1'b0, 32'h0000_0311);
        send_poll(1'b0, 32'h0000_0311);
        write_reg(bdpc_pkg::REG_MULTI_RESET_MS, 16'd0);
        send_poll(1'b1, 32'h0000_0311);

        // Random, sender mostly busy and sink mostly stalled
        tick_now = $urandom;
        configure(1'b0, 16'd20, 16'd200, 16'd300, 4'hF);
        run_random(350);

        // Random, sender mostly idle, at the register extremes
        tx_idle_pct  = 71;
        rx_stall_pct = 7;
        configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'($urandom_range(0, 15)));
        run_random(150);
        configure(1'b0, 16'd0, 16'd0, 16'd0, 4'h0);
        run_random(150);

        // No idling: fill the block against a long sink hold-off
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        configure(1'($urandom_range(0, 1)), 16'($urandom_range(0, 100)),
                  16'($urandom_range(0, 400)), 16'($urandom_range(0, 600)),
                  4'($urandom_range(0, 15)));
        rx_hold_requests++;
        run_random(80);
        wait_drained();
        run_random(40);

        // Wrap the press counter: fast presses, idle window never reached
        configure(1'b0, 16'd0, 16'hFFFF, 16'hFFFF, 4'h5);
        repeat (260) begin
            tick_now += 1;
            send_poll(1'b1, tick_now);
            tick_now += 1;
            send_poll(1'b0, tick_now);
        end

        wait_drained();
        repeat (4) @(negedge i_clk);
        $display("summary: %0d polls, %0d results, %0d register writes, %0d mismatches",
                 polls_sent, sb.n_checked, reg_writes, sb.n_errors);
        $display("summary: strobes down %0d, press %0d, long %0d, up %0d",
                 sb.n_down, sb.n_press, sb.n_long, sb.n_up);
        if (sb.n_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
